// ===== rtl/core/lru_key_value_cache_macros.svh =====
// Assertion macros shared by the LRU key-value cache checkers.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LKVC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lkvc assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LKVC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lkvc assertion failed");

`endif

// ===== rtl/core/lkvc_pkg.sv =====
// Shared constants and types for the LRU key-value cache.
package lkvc_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int KEY_BITS    = 16;
	localparam int VALUE_W     = 32;
	localparam int CAP_W       = 5;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef logic [IDX_W-1:0] rank_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic {
		FUNC_GET = 1'b0,
		FUNC_PUT = 1'b1
	} func_t;

endpackage

// ===== rtl/core/lru_key_value_cache.sv =====
// LRU key-value cache: fully associative table with least-recently-used eviction.
// Each item passes through the input register, and its result through the result register.
// Throughput: one item per cycle unless a valid result is stalled; the parallel key compare
// and rank update of all entries complete between the input register and the result register.
// Reset (asynchronous, active low) empties the table, clears the count and sets capacity to 16.
module lru_key_value_cache (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [lkvc_pkg::CAP_W-1:0]          cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [lkvc_pkg::KEY_BITS-1:0]       key,
	input  logic signed [lkvc_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic signed [lkvc_pkg::VALUE_W-1:0] read_value
);
	import lkvc_pkg::*;

	// Input register
	logic                valid_s1;
	func_t               func_s1;
	logic [KEY_BITS-1:0] key_s1;
	logic [VALUE_W-1:0]  value_s1;

	// Result register
	logic               out_valid_q;
	logic               hit_q;
	logic [VALUE_W-1:0] rdata_q;

	// Table state
	logic [MAX_ENTRIES-1:0]               valid_q;
	rank_t                                rank_q   [MAX_ENTRIES];
	logic [KEY_BITS-1:0]                  keys_q   [MAX_ENTRIES];
	logic [VALUE_W-1:0]                   values_q [MAX_ENTRIES];
	count_t                               count_q;
	logic [CAP_W-1:0]                     capacity_q;

	// Next-state and write controls
	logic                   advance;
	logic                   fire;
	logic [MAX_ENTRIES-1:0] valid_n;
	rank_t                  rank_n [MAX_ENTRIES];
	count_t                 count_n;
	logic                   key_we;
	logic                   val_we;
	rank_t                  wr_idx;
	logic                   hit_any;
	logic [VALUE_W-1:0]     rdata_n;

	// The input register moves on when the result register is empty or being taken.
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Lookup, recency update, insertion and eviction for the item in the input register.
	always_comb begin
		logic [MAX_ENTRIES-1:0] match;
		rank_t                  hit_idx;
		rank_t                  old_rank;
		rank_t                  free_idx;
		logic                   has_free;
		rank_t                  oldest_idx;
		rank_t                  ins_idx;
		rank_t                  ev_idx;
		logic                   ev_found;
		count_t                 cap_eff;

		valid_n  = valid_q;
		rank_n   = rank_q;
		count_n  = count_q;
		key_we   = 1'b0;
		val_we   = 1'b0;
		wr_idx   = '0;
		ev_idx   = '0;
		ev_found = 1'b0;

		// Capacity above the table size saturates.
		if (int'(capacity_q) > MAX_ENTRIES) begin
			cap_eff = CNT_W'(MAX_ENTRIES);
		end else begin
			cap_eff = CNT_W'(capacity_q);
		end

		// Parallel key compare; at most one valid entry matches.
		hit_idx = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = valid_q[i] && (keys_q[i] == key_s1);
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
		hit_any  = |match;
		old_rank = rank_q[hit_idx];

		// Lowest free slot, and the oldest entry for the case of a full table.
		free_idx   = '0;
		has_free   = 1'b0;
		oldest_idx = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
				has_free = 1'b1;
			end
			if (valid_q[i] && (rank_q[i] == IDX_W'(count_q - 1'b1))) begin
				oldest_idx = IDX_W'(i);
			end
		end
		ins_idx = has_free ? free_idx : oldest_idx;

		if (func_s1 == FUNC_GET && hit_any) begin
			rdata_n = values_q[hit_idx];
		end else begin
			rdata_n = '0;
		end

		if (fire) begin
			if (hit_any) begin
				// Touch: entries younger than the hit age by one.
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (valid_q[i] && (rank_q[i] < old_rank)) begin
						rank_n[i] = rank_q[i] + 1'b1;
					end
				end
				rank_n[hit_idx] = '0;
				if (func_s1 == FUNC_PUT) begin
					val_we = 1'b1;
					wr_idx = hit_idx;
				end
			end else if (func_s1 == FUNC_PUT) begin
				// Insert: a full table reuses the oldest slot, all others age by one.
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (valid_q[i] && (IDX_W'(i) != ins_idx)) begin
						rank_n[i] = rank_q[i] + 1'b1;
					end
				end
				valid_n[ins_idx] = 1'b1;
				rank_n[ins_idx]  = '0;
				key_we           = 1'b1;
				val_we           = 1'b1;
				wr_idx           = ins_idx;
				if (has_free) begin
					count_n = count_q + 1'b1;
				end
			end

			// A put that leaves the table over capacity evicts the oldest entry.
			if (func_s1 == FUNC_PUT && (count_n > cap_eff)) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (valid_n[i] && (rank_n[i] == IDX_W'(count_n - 1'b1))) begin
						ev_idx   = IDX_W'(i);
						ev_found = 1'b1;
					end
				end
				if (ev_found) begin
					valid_n[ev_idx] = 1'b0;
					rank_n[ev_idx]  = '0;
					count_n         = count_n - 1'b1;
				end
			end
		end
	end

	// Input register: loads whenever it is empty or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1  <= func_t'(func);
			key_s1   <= key;
			value_s1 <= value;
		end
	end

	// Result register: holds while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_q   <= hit_any;
			rdata_q <= rdata_n;
		end
	end

	// Control state of the table and the capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			count_q    <= '0;
			capacity_q <= CAP_RESET;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_n;
			count_q <= count_n;
			rank_q  <= rank_n;
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
		end
	end

	// Key and value storage, written at one slot per item.
	always_ff @(posedge clk) begin
		if (key_we) begin
			keys_q[wr_idx] <= key_s1;
		end
		if (val_we) begin
			values_q[wr_idx] <= value_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = rdata_q;

endmodule

// ===== rtl/core/lkvc_checker.sv =====
// Port-level checker for the LRU key-value cache, bound to the top level.
`include "lru_key_value_cache_macros.svh"

module lkvc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                hit,
	input logic signed [lkvc_pkg::VALUE_W-1:0] read_value
);
	import lkvc_pkg::*;

	// A stalled result stays valid and unchanged.
	`LKVC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hit) && $stable(read_value))

	// A miss never carries data; a put carries none either, but this assertion checks only misses.
	`LKVC_ASSERT_IMP(a_miss_zero, out_valid && !hit, read_value == '0)

	// The input side stalls only behind a stalled result.
	`LKVC_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

	// An accepted item has a result on the output once it has passed the input and result registers.
	`LKVC_ASSERT_IMP(a_accept_result, in_valid && !in_stall, ##2 out_valid)

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);
